@@ rtl/core/alls_pkg.sv @@
// Package for the linked set block: codes, widths, state encoding.
package alls_pkg;

    // Default slot count of the store
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((CMD_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + COUNT_W + 7) / 8) * 8;

    // Operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_ADD_RD,
        S_ADD_WR,
        S_REM_PREV,
        S_REM_AT,
        S_RESP
    } state_t;

endpackage

@@ rtl/core/alls_slot_store.sv @@
// Slot store: value and link memories, one write and one registered read each.
module alls_slot_store #(
    parameter int CAPACITY = alls_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int PTR_W    = $clog2(CAPACITY + 1)
) (
    input  logic                       aclk,
    input  logic                       val_we,
    input  logic                       link_we,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [alls_pkg::VALUE_W-1:0] val_wdata,
    input  logic [PTR_W-1:0]           link_wdata,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [alls_pkg::VALUE_W-1:0] rd_val,
    output logic [PTR_W-1:0]           rd_link
);

    logic [alls_pkg::VALUE_W-1:0] val_mem [CAPACITY];
    logic [PTR_W-1:0]             link_mem [CAPACITY];

    // Value memory
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[wr_addr] <= val_wdata;
        end
        rd_val <= val_mem[rd_addr];
    end

    // Link memory
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[wr_addr] <= link_wdata;
        end
        rd_link <= link_mem[rd_addr];
    end

endmodule

@@ rtl/core/array_linked_set_with_free_list_top.sv @@
// Top level of the linked set: stream ports, walk controller, free list.
//
// Keeps a set of distinct 32-bit values in CAPACITY slots chained as a used
// list and a free list. Every transaction on the input stream (add, remove,
// search) gives exactly one result transaction carrying a status and the
// element count after the operation. Items are handled one at a time: the
// walk visits one used slot at a time, reading it from memory and then
// comparing it. An add also reads the free-list link. After reset the block
// builds the free list in the link memory, with s_tready low. A finished
// result waits in the output register while the next transaction is
// accepted.
module array_linked_set_with_free_list_top #(
    parameter int CAPACITY = alls_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [alls_pkg::S_TDATA_W-1:0]  s_tdata,  // [1:0] cmd, [33:2] elem_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [alls_pkg::M_TDATA_W-1:0]  m_tdata   // [1:0] status, [6:2] count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);

    alls_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0]              cur_reg, cur_next;
    logic [PTR_W-1:0]              prev_reg, prev_next;
    logic [PTR_W-1:0]              after_reg, after_next;
    logic [PTR_W-1:0]              steps_reg, steps_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              free_reg, free_next;
    logic [PTR_W-1:0]              count_reg, count_next;
    logic [PTR_W-1:0]              init_reg, init_next;
    logic [alls_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [alls_pkg::VALUE_W-1:0]  val_reg, val_next;
    alls_pkg::status_t             status_reg, status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [alls_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Store access
    logic                          val_we, link_we;
    logic [ADDR_W-1:0]             wr_addr, rd_addr;
    logic [alls_pkg::VALUE_W-1:0]  val_wdata, rd_val;
    logic [PTR_W-1:0]              link_wdata, rd_link;

    logic s_fire;

    alls_slot_store #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .PTR_W    (PTR_W)
    ) u_store (
        .aclk       (aclk),
        .val_we     (val_we),
        .link_we    (link_we),
        .wr_addr    (wr_addr),
        .val_wdata  (val_wdata),
        .link_wdata (link_wdata),
        .rd_addr    (rd_addr),
        .rd_val     (rd_val),
        .rd_link    (rd_link)
    );

    assign s_tready = (state_reg == alls_pkg::S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= alls_pkg::S_INIT;
            init_reg     <= '0;
            head_reg     <= NIL;
            free_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            head_reg     <= head_next;
            free_reg     <= free_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Walk and payload registers
    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        after_reg   <= after_next;
        steps_reg   <= steps_next;
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Next state, store access and result
    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        after_next    = after_reg;
        steps_next    = steps_reg;
        head_next     = head_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        val_we     = 1'b0;
        link_we    = 1'b0;
        wr_addr    = cur_reg[ADDR_W-1:0];
        val_wdata  = val_reg;
        link_wdata = free_reg;
        rd_addr    = cur_reg[ADDR_W-1:0];

        // Result leaves the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            // Build the free list: slot i links to i+1, last to null
            alls_pkg::S_INIT: begin
                link_we    = 1'b1;
                wr_addr    = init_reg[ADDR_W-1:0];
                link_wdata = init_reg + PTR_W'(1);
                init_next  = init_reg + PTR_W'(1);
                if (init_reg == LAST_SLOT) begin
                    state_next = alls_pkg::S_IDLE;
                end
            end

            alls_pkg::S_IDLE: begin
                if (s_fire) begin
                    cmd_next   = s_tdata[alls_pkg::CMD_W-1:0];
                    val_next   = s_tdata[alls_pkg::CMD_W +: alls_pkg::VALUE_W];
                    cur_next   = head_reg;
                    prev_next  = NIL;
                    steps_next = '0;
                    if (s_tdata[alls_pkg::CMD_W-1:0] == alls_pkg::CMD_ADD ||
                        s_tdata[alls_pkg::CMD_W-1:0] == alls_pkg::CMD_REMOVE ||
                        s_tdata[alls_pkg::CMD_W-1:0] == alls_pkg::CMD_SEARCH) begin
                        state_next = alls_pkg::S_WALK;
                    end else begin
                        // Unused command: no state change
                        status_next = alls_pkg::STS_MISS;
                        state_next  = alls_pkg::S_RESP;
                    end
                end
            end

            // Issue the read of the current slot, or end the walk
            alls_pkg::S_WALK: begin
                rd_addr = cur_reg[ADDR_W-1:0];
                if (steps_reg == NIL || cur_reg >= NIL) begin
                    if (alls_pkg::cmd_t'(cmd_reg) == alls_pkg::CMD_ADD) begin
                        if (free_reg >= NIL) begin
                            status_next = alls_pkg::STS_FULL;
                            state_next  = alls_pkg::S_RESP;
                        end else begin
                            state_next = alls_pkg::S_ADD_RD;
                        end
                    end else begin
                        status_next = alls_pkg::STS_MISS;
                        state_next  = alls_pkg::S_RESP;
                    end
                end else begin
                    state_next = alls_pkg::S_CHECK;
                end
            end

            // Compare the slot just read
            alls_pkg::S_CHECK: begin
                if (rd_val == val_reg) begin
                    after_next = rd_link;
                    unique case (alls_pkg::cmd_t'(cmd_reg))
                        alls_pkg::CMD_REMOVE: state_next = alls_pkg::S_REM_PREV;
                        alls_pkg::CMD_SEARCH: begin
                            status_next = alls_pkg::STS_OK;
                            state_next  = alls_pkg::S_RESP;
                        end
                        default: begin
                            status_next = alls_pkg::STS_MISS;
                            state_next  = alls_pkg::S_RESP;
                        end
                    endcase
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    steps_next = steps_reg + PTR_W'(1);
                    state_next = alls_pkg::S_WALK;
                end
            end

            // Read the link of the first free slot
            alls_pkg::S_ADD_RD: begin
                rd_addr    = free_reg[ADDR_W-1:0];
                state_next = alls_pkg::S_ADD_WR;
            end

            // Fill the taken slot and link it at the head
            alls_pkg::S_ADD_WR: begin
                val_we      = 1'b1;
                link_we     = 1'b1;
                wr_addr     = free_reg[ADDR_W-1:0];
                val_wdata   = val_reg;
                link_wdata  = head_reg;
                head_next   = free_reg;
                free_next   = rd_link;
                count_next  = count_reg + PTR_W'(1);
                status_next = alls_pkg::STS_OK;
                state_next  = alls_pkg::S_RESP;
            end

            // Unlink: predecessor (or head) skips the matched slot
            alls_pkg::S_REM_PREV: begin
                if (prev_reg < NIL) begin
                    link_we    = 1'b1;
                    wr_addr    = prev_reg[ADDR_W-1:0];
                    link_wdata = after_reg;
                end else begin
                    head_next = after_reg;
                end
                state_next = alls_pkg::S_REM_AT;
            end

            // Push the freed slot onto the free list
            alls_pkg::S_REM_AT: begin
                link_we    = 1'b1;
                wr_addr    = cur_reg[ADDR_W-1:0];
                link_wdata = free_reg;
                free_next  = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - PTR_W'(1);
                end
                status_next = alls_pkg::STS_OK;
                state_next  = alls_pkg::S_RESP;
            end

            // Hand the result to the output register once it is free
            alls_pkg::S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = alls_pkg::M_TDATA_W'(
                        {alls_pkg::COUNT_W'(count_reg), status_reg});
                    state_next    = alls_pkg::S_IDLE;
                end
            end

            default: state_next = alls_pkg::S_IDLE;
        endcase
    end

endmodule
